// ----- rtl/wflrm_pkg.sv -----
// wflrm_pkg: shared types and constants of the letter rack match unit
// no dependencies; used by the bin store and the top level
`default_nettype none

package wflrm_pkg;

    // bin layout: a..z in bins 0..25, everything else in the shared bin
    localparam int BIN_COUNT = 27;
    localparam int BIN_W     = 5;
    localparam int CNT_W     = 5;

    localparam logic [BIN_W-1:0] OTHER_BIN = BIN_W'(26);

    localparam logic [7:0] LOW_LETTER  = 8'd97;
    localparam logic [7:0] HIGH_LETTER = 8'd122;
    localparam logic [7:0] BRACE_BYTE  = 8'd123;

    // action codes of an input word
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_RACK  = 2'd1;
    localparam logic [1:0] ACT_CHAR  = 2'd2;

    // read request into a bin store
    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
    } t_bin_rd;

    // write request into a bin store
    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_bin_wr;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= LOW_LETTER) && (c <= HIGH_LETTER);
    endfunction

    // bin of a byte; non-letters land in the shared bin
    function automatic logic [BIN_W-1:0] bin_of(input logic [7:0] c);
        logic [7:0] diff;
        diff = c - LOW_LETTER;
        return is_letter(c) ? diff[BIN_W-1:0] : OTHER_BIN;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wflrm_if.sv -----
// wflrm_if: valid/ready channels for input words and match results
// depends on nothing outside this file
`default_nettype none

interface wflrm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, action, char_byte, last_char, input ready);
    modport sink   (input valid, action, char_byte, last_char, output ready);
endinterface

interface wflrm_out_if;
    logic valid;
    logic ready;
    logic match;
    logic length_ok;

    modport source (output valid, match, length_ok, input ready);
    modport sink   (input valid, match, length_ok, output ready);
endinterface

`default_nettype wire

// ----- rtl/wflrm_bin_store.sv -----
// wflrm_bin_store: 27-entry count memory with valid bits, bulk clear and
// write-to-read forwarding; depends on wflrm_pkg
`default_nettype none

module wflrm_bin_store
    import wflrm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bin_rd          i_rd,
    input  wire t_bin_wr          i_wr,
    input  wire logic             i_clr,
    output logic [CNT_W-1:0]      o_rd_data
);

    logic [CNT_W-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_valid;
    logic [CNT_W-1:0] r_q;
    logic [BIN_W-1:0] r_addr;
    logic             r_fwd_hit;
    logic [CNT_W-1:0] r_fwd_data;

    // memory array: synchronous write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q        <= mem[i_rd.addr];
            r_addr     <= i_rd.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // valid bits stand in for clearing the whole array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_fwd_hit <= i_wr.en && (i_wr.addr == i_rd.addr);
            end
        end
    end

    // a write landing with the read takes priority over the stale array data
    assign o_rd_data = r_fwd_hit       ? r_fwd_data :
                       r_valid[r_addr] ? r_q        : '0;

endmodule

`default_nettype wire

// ----- rtl/word_from_letter_rack_match_unit.sv -----
// word_from_letter_rack_match_unit: one word per cycle while the output is
// not full; the rack and word bin counts live in two memories read at accept
// and written back by the update stage. A result enters the output register
// as its last character leaves stage one; the rate is set by the single
// read/write pass per bin. Synchronous active-low reset empties rack and word
// at once through valid bits (no clearing pass) and sets word_length to 1.
`default_nettype none

module word_from_letter_rack_match_unit
    import wflrm_pkg::*;
#(
    parameter int RACK_MAX = 16,
    parameter int WORD_MAX = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    wflrm_in_if.sink        i_word,
    wflrm_out_if.source     o_result
);

    localparam logic [CNT_W-1:0] RackLimit = CNT_W'(RACK_MAX);
    localparam logic [CNT_W-1:0] WordLimit = CNT_W'(WORD_MAX);

    logic [4:0]       r_word_length;

    // read stage registers
    logic             r_s1_vld;
    logic [1:0]       r_s1_action;
    logic             r_s1_last;
    logic             r_s1_letter;
    logic             r_s1_brace;
    logic [BIN_W-1:0] r_s1_bin;

    // scalar rack/word state
    logic [CNT_W-1:0] r_rack_size;
    logic [CNT_W-1:0] r_word_len;
    logic             r_failed;
    logic             r_too_long;
    logic [BIN_W-1:0] r_over;
    logic [BIN_W-1:0] r_distinct;

    logic             r_out_vld;
    logic             r_match;
    logic             r_len_ok;

    logic [CNT_W-1:0] rack_cnt;
    logic [CNT_W-1:0] word_cnt;

    t_bin_rd          rd_req;
    t_bin_wr          rack_wr;
    t_bin_wr          word_wr;
    logic             rack_clr;
    logic             word_clr;

    logic             accept;
    logic             s1_res;
    logic             s1_go;

    logic [CNT_W-1:0] n_rack_size;
    logic [CNT_W-1:0] n_word_len;
    logic             n_failed;
    logic             n_too_long;
    logic [BIN_W-1:0] n_over;
    logic [BIN_W-1:0] n_distinct;
    logic             n_len_ok;
    logic             n_match;

    // handshake: stage one moves unless its result finds the output full
    assign s1_res         = r_s1_vld && (r_s1_action == ACT_CHAR) && r_s1_last;
    assign s1_go          = r_s1_vld && (!s1_res || !r_out_vld || o_result.ready);
    assign i_word.ready   = !r_s1_vld || s1_go;
    assign accept         = i_word.valid && i_word.ready;

    assign rd_req.en      = accept;
    assign rd_req.addr    = bin_of(i_word.char_byte);

    wflrm_bin_store u_rack_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (rack_wr),
        .i_clr     (rack_clr),
        .o_rd_data (rack_cnt)
    );

    wflrm_bin_store u_word_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (word_wr),
        .i_clr     (word_clr),
        .o_rd_data (word_cnt)
    );

    // update stage: at most one bin read-modify-write or a rack/word clear, plus running over/distinct counts
    always_comb begin
        rack_wr      = '{en: 1'b0, addr: r_s1_bin, data: rack_cnt + CNT_W'(1)};
        word_wr      = '{en: 1'b0, addr: r_s1_bin, data: word_cnt + CNT_W'(1)};
        rack_clr     = 1'b0;
        word_clr     = 1'b0;
        n_rack_size  = r_rack_size;
        n_word_len   = r_word_len;
        n_failed     = r_failed;
        n_too_long   = r_too_long;
        n_over       = r_over;
        n_distinct   = r_distinct;
        if (s1_go) begin
            case (r_s1_action)
                ACT_CLEAR: begin
                    // every bin the word uses now exceeds an empty rack
                    rack_clr    = 1'b1;
                    n_rack_size = '0;
                    n_over      = r_distinct;
                end
                ACT_RACK: begin
                    if (r_rack_size < RackLimit) begin
                        rack_wr.en  = 1'b1;
                        n_rack_size = r_rack_size + CNT_W'(1);
                        if (word_cnt == rack_wr.data) begin
                            n_over = r_over - BIN_W'(1);
                        end
                    end
                end
                ACT_CHAR: begin
                    if (r_word_len >= WordLimit) begin
                        n_too_long = 1'b1;
                        n_failed   = 1'b1;
                    end else begin
                        n_word_len = r_word_len + CNT_W'(1);
                        if (r_s1_letter || r_s1_brace) begin
                            word_wr.en = !r_s1_last;
                            if (word_cnt == '0) begin
                                n_distinct = r_distinct + BIN_W'(1);
                            end
                            if (word_cnt == rack_cnt) begin
                                n_over = r_over + BIN_W'(1);
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    word_clr = r_s1_last;
                end
                default: begin
                end
            endcase
        end
        n_len_ok = !n_too_long && (n_word_len == r_word_length);
        n_match  = n_len_ok && !n_failed && (r_word_length <= r_rack_size) &&
                   (n_over == '0);
    end

    // stage one register and scalar state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= 5'd1;
            r_s1_vld      <= 1'b0;
            r_rack_size   <= '0;
            r_word_len    <= '0;
            r_failed      <= 1'b0;
            r_too_long    <= 1'b0;
            r_over        <= '0;
            r_distinct    <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_word_length <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            r_rack_size <= n_rack_size;
            if (word_clr) begin
                r_word_len <= '0;
                r_failed   <= 1'b0;
                r_too_long <= 1'b0;
                r_over     <= '0;
                r_distinct <= '0;
            end else begin
                r_word_len <= n_word_len;
                r_failed   <= n_failed;
                r_too_long <= n_too_long;
                r_over     <= n_over;
                r_distinct <= n_distinct;
            end
            if (s1_go && s1_res) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_word.action;
            r_s1_last   <= i_word.last_char;
            r_s1_letter <= is_letter(i_word.char_byte);
            r_s1_brace  <= (i_word.char_byte == BRACE_BYTE);
            r_s1_bin    <= bin_of(i_word.char_byte);
        end
        if (s1_go && s1_res) begin
            r_match  <= n_match;
            r_len_ok <= n_len_ok;
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.match     = r_match;
    assign o_result.length_ok = r_len_ok;

    // rack never fills past its limit
    a_rack_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rack_size <= RackLimit)
        else $error("rack size over limit");

    // word length count stays within its limit
    a_word_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_len <= WordLimit)
        else $error("word length over limit");

    // exceeding bins are a subset of the bins the word uses
    a_over_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over <= r_distinct)
        else $error("over count exceeds distinct bin count");

    // a finished word leaves no word state behind
    a_word_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_res) |=> (r_word_len == '0 && r_over == '0 && !r_failed))
        else $error("word state not cleared after result");

endmodule

`default_nettype wire
